FILE: rtl/core/ascii_to_unsigned_radix_parser_assert.svh
// assertion macros for the ascii to unsigned radix parser
`ifndef ASCII_TO_UNSIGNED_RADIX_PARSER_ASSERT_SVH
`define ASCII_TO_UNSIGNED_RADIX_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define ATUR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ATUR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ATUR_ASSERT_NOW(lbl, ante, cons, msg)
`define ATUR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/core/atur_pkg.sv
// types, constants and decode functions shared by the parser modules
`timescale 1ns / 1ps
`default_nettype none

package atur_pkg;

	localparam int VALUE_W = 32;
	localparam int STOP_W  = 16;
	localparam int BASE_W  = 6;
	localparam int PROD_W  = VALUE_W + BASE_W;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 32'hffff_ffff;

	localparam logic [BASE_W-1:0] RADIX_INFER = 6'd0;
	localparam logic [BASE_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [BASE_W-1:0] RADIX_OCT   = 6'd8;
	localparam logic [BASE_W-1:0] RADIX_DEC   = 6'd10;
	localparam logic [BASE_W-1:0] RADIX_HEX   = 6'd16;
	localparam logic [BASE_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [BASE_W-1:0] NO_DIGIT    = 6'd63;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7a;

	typedef enum logic [2:0] {
		PH_WS,
		PH_SIGN,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t               phase;
		logic [VALUE_W-1:0]   acc;
		logic [BASE_W-1:0]    radix;
		logic                 any_digit;
		logic                 ovf;
	} parse_state_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [STOP_W-1:0]  stop;
		logic               converted;
		logic               overflowed;
	} result_t;

	localparam parse_state_t PARSE_CLEAR = '{
		phase:     PH_WS,
		acc:       '0,
		radix:     '0,
		any_digit: 1'b0,
		ovf:       1'b0
	};

	function automatic logic is_space(input logic [7:0] c);
		return (c inside {CH_SPACE, [CH_TAB:CH_CR]});
	endfunction

	// digit value 0..35, or a code above every legal radix
	function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
		logic [BASE_W-1:0] d;
		d = NO_DIGIT;
		if (c inside {[CH_0:CH_9]})
			d = BASE_W'(c - CH_0);
		else if (c inside {[CH_LA:CH_LZ]})
			d = BASE_W'(c - CH_LA) + RADIX_DEC;
		else if (c inside {[CH_UA:CH_UZ]})
			d = BASE_W'(c - CH_UA) + RADIX_DEC;
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ascii_to_unsigned_radix_parser.sv
// Streaming unsigned 32-bit number parser, one string byte per transfer, in the style of
// strtoul. A byte is registered on acceptance and parsed in the following cycle, so a
// new byte can be taken every cycle while in_stall is low; the result of a string
// is loaded into the output register once its terminating byte (zero, or a byte
// with last_byte set) has been parsed and the output slot is free. A waiting result
// only holds off the input once a further terminating byte is ready to be parsed.
// The per-byte path is the 32 x 6 multiply-add of the accumulator with its overflow
// check, which also sets the clock. number_base is sampled when the first significant
// byte of a string is parsed, so write it only while the parser is idle. There is no
// clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "ascii_to_unsigned_radix_parser_assert.svh"

module ascii_to_unsigned_radix_parser
	import atur_pkg::*;
#(
	parameter int OFFSET_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [BASE_W-1:0]  cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VALUE_W-1:0] parsed_value,
	output logic [STOP_W-1:0]  stop_offset,
	output logic               converted,
	output logic               overflowed
);

	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   last_s1;
	logic [BASE_W-1:0]      number_base_q;
	parse_state_t           state_q;
	parse_state_t           state_d;
	logic [OFFSET_BITS-1:0] byte_pos_q;
	logic [OFFSET_BITS-1:0] byte_pos_d;
	logic [OFFSET_BITS-1:0] stop_pos_q;
	logic [OFFSET_BITS-1:0] stop_pos_d;
	logic                   emit;
	logic                   out_ready;
	logic                   advance;
	logic                   in_xfer;
	result_t                result;

	// the byte in s1 moves on unless it ends a string and the result slot is taken
	assign advance  = valid_s1 && (!emit || out_ready);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= RADIX_INFER;
		end else if (cfg_we) begin
			number_base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_s1 <= char_code;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= PARSE_CLEAR;
			byte_pos_q <= '0;
			stop_pos_q <= '0;
		end else if (advance) begin
			if (emit) begin
				state_q    <= PARSE_CLEAR;
				byte_pos_q <= '0;
				stop_pos_q <= '0;
			end else begin
				state_q    <= state_d;
				byte_pos_q <= byte_pos_d;
				stop_pos_q <= stop_pos_d;
			end
		end
	end

	atur_step #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_step (
		.state_q    (state_q),
		.byte_pos_q (byte_pos_q),
		.stop_pos_q (stop_pos_q),
		.char_code  (char_s1),
		.last_byte  (last_s1),
		.number_base(number_base_q),
		.state_d    (state_d),
		.byte_pos_d (byte_pos_d),
		.stop_pos_d (stop_pos_d),
		.emit       (emit),
		.result     (result)
	);

	atur_outreg u_outreg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && emit),
		.res         (result),
		.ready       (out_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.parsed_value(parsed_value),
		.stop_offset (stop_offset),
		.converted   (converted),
		.overflowed  (overflowed)
	);

	`ATUR_ASSERT_NOW(a_ovf_all_ones, out_valid && overflowed, (parsed_value == VALUE_MAX) && converted, "overflow result without all-ones value")
	`ATUR_ASSERT_NOW(a_none_is_zero, out_valid && !converted, (parsed_value == '0) && (stop_offset == '0), "unconverted result carries data")
	`ATUR_ASSERT_NOW(a_acc_needs_digit, state_q.acc != '0, state_q.any_digit, "accumulator set without a digit")
	`ATUR_ASSERT_NEXT(a_string_end_clears, advance && emit, (state_q == PARSE_CLEAR) && (byte_pos_q == '0), "parse state not cleared at string end")

endmodule

`default_nettype wire

FILE: rtl/core/atur_step.sv
// per-byte parse step: next parse state, positions and the result of a string
`timescale 1ns / 1ps
`default_nettype none

module atur_step
	import atur_pkg::*;
#(
	parameter int OFFSET_BITS = 16
) (
	input  parse_state_t           state_q,
	input  logic [OFFSET_BITS-1:0] byte_pos_q,
	input  logic [OFFSET_BITS-1:0] stop_pos_q,
	input  logic [7:0]             char_code,
	input  logic                   last_byte,
	input  logic [BASE_W-1:0]      number_base,
	output parse_state_t           state_d,
	output logic [OFFSET_BITS-1:0] byte_pos_d,
	output logic [OFFSET_BITS-1:0] stop_pos_d,
	output logic                   emit,
	output result_t                result
);

	logic                   non_nul;
	logic                   start_num;
	logic                   zero_lead;
	logic                   take_dig;
	logic                   is_x;
	logic                   digit_ok;
	logic                   prod_ovf;
	logic [BASE_W-1:0]      digit;
	logic [BASE_W-1:0]      start_radix;
	logic [BASE_W-1:0]      radix_sel;
	logic [PROD_W-1:0]      prod;
	logic [OFFSET_BITS-1:0] pos_inc;

	assign non_nul = (char_code != CH_NUL);
	assign is_x    = (char_code == CH_LX) || (char_code == CH_UX);
	assign digit   = digit_of(char_code);
	assign pos_inc = (byte_pos_q == '1) ? byte_pos_q : byte_pos_q + OFFSET_BITS'(1);

	// first byte past the whitespace and the optional plus sign
	assign start_num = non_nul && (((state_q.phase == PH_WS) && !is_space(char_code)
		&& (char_code != CH_PLUS)) || (state_q.phase == PH_SIGN));
	assign zero_lead = start_num && (char_code == CH_0)
		&& ((number_base == RADIX_INFER) || (number_base == RADIX_HEX));
	assign take_dig  = non_nul && ((start_num && !zero_lead)
		|| ((state_q.phase == PH_ZERO) && !is_x) || (state_q.phase == PH_DIGITS));

	assign start_radix = (number_base == RADIX_INFER) ? RADIX_DEC : number_base;
	assign radix_sel   = start_num ? start_radix : state_q.radix;
	assign digit_ok    = (radix_sel >= RADIX_MIN) && (radix_sel <= RADIX_MAX)
		&& (digit < radix_sel);

	// 32 x 6 multiply-add, overflow seen exactly in the top bits
	assign prod     = PROD_W'(state_q.acc) * PROD_W'(radix_sel) + PROD_W'(digit);
	assign prod_ovf = (prod[PROD_W-1:VALUE_W] != '0);

	always_comb begin
		state_d.phase     = state_q.phase;
		state_d.acc       = state_q.acc;
		state_d.radix     = state_q.radix;
		state_d.any_digit = state_q.any_digit;
		state_d.ovf       = state_q.ovf;
		stop_pos_d        = stop_pos_q;
		byte_pos_d        = non_nul ? pos_inc : byte_pos_q;

		if (start_num) begin
			state_d.radix = start_radix;
		end
		if (zero_lead) begin
			state_d.phase     = PH_ZERO;
			state_d.any_digit = 1'b1;
			state_d.acc       = '0;
			state_d.radix     = (number_base == RADIX_INFER) ? RADIX_OCT : RADIX_HEX;
			stop_pos_d        = pos_inc;
		end else if (take_dig) begin
			state_d.phase = (!digit_ok || prod_ovf) ? PH_DONE : PH_DIGITS;
			if (digit_ok) begin
				state_d.any_digit = 1'b1;
				if (prod_ovf) begin
					state_d.ovf = 1'b1;
					state_d.acc = VALUE_MAX;
					stop_pos_d  = byte_pos_q;
				end else begin
					state_d.acc = prod[VALUE_W-1:0];
					stop_pos_d  = pos_inc;
				end
			end
		end else if (non_nul && (state_q.phase == PH_ZERO) && is_x) begin
			state_d.phase = PH_DIGITS;
			state_d.radix = RADIX_HEX;
		end else if (non_nul && (state_q.phase == PH_WS) && (char_code == CH_PLUS)) begin
			state_d.phase = PH_SIGN;
		end
	end

	assign emit = !non_nul || last_byte;

	always_comb begin
		result.value      = state_d.any_digit ? state_d.acc : '0;
		result.stop       = state_d.any_digit ? STOP_W'(stop_pos_d) : '0;
		result.converted  = state_d.any_digit;
		result.overflowed = state_d.ovf;
	end

endmodule

`default_nettype wire

FILE: rtl/core/atur_outreg.sv
// result register on the output channel
`timescale 1ns / 1ps
`default_nettype none

module atur_outreg
	import atur_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  result_t            res,
	output logic               ready,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VALUE_W-1:0] parsed_value,
	output logic [STOP_W-1:0]  stop_offset,
	output logic               converted,
	output logic               overflowed
);

	logic    valid_q;
	result_t res_q;

	// free when empty or when the waiting result leaves this cycle
	assign ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign parsed_value = res_q.value;
	assign stop_offset  = res_q.stop;
	assign converted    = res_q.converted;
	assign overflowed   = res_q.overflowed;

endmodule

`default_nettype wire

FILE: tb/ascii_to_unsigned_radix_parser_tb.sv
// self-checking testbench for the streaming ascii to unsigned number parser
`timescale 1ns / 1ps

module ascii_to_unsigned_radix_parser_tb
	import atur_pkg::*;
();

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 12;
	localparam int IDLE_PAUSE   = 4;
	localparam logic [STOP_W-1:0] POS_MAX = '1;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [BASE_W-1:0]  cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         char_code;
	logic               last_byte;
	logic               out_valid;
	logic               out_stall;
	logic [VALUE_W-1:0] parsed_value;
	logic [STOP_W-1:0]  stop_offset;
	logic               converted;
	logic               overflowed;

	ascii_to_unsigned_radix_parser #(
		.OFFSET_BITS(16)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.parsed_value (parsed_value),
		.stop_offset  (stop_offset),
		.converted    (converted),
		.overflowed   (overflowed)
	);

	// parser state as predicted
	logic [BASE_W-1:0]  m_base;
	phase_t             m_phase;
	logic [VALUE_W-1:0] m_acc;
	logic [BASE_W-1:0]  m_radix;
	logic [STOP_W-1:0]  m_pos;
	logic [STOP_W-1:0]  m_stop;
	logic               m_any;
	logic               m_ovf;

	result_t expected_numbers[$];

	int  errors;
	int  checked;
	int  n_strings;
	int  n_overflow;
	int  n_stalled;
	int  tx_total;
	int  cycles;
	int  hold_left;
	bit  tx_idling;
	bit  rx_idling;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly back to back, sometimes short gaps, rarely long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [STOP_W-1:0] pos_next(input logic [STOP_W-1:0] p);
		return (p == POS_MAX) ? p : p + 1'b1;
	endfunction

	function automatic int char_value(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return int'(c) - int'(CH_0);
		if (c >= CH_LA && c <= CH_LZ)
			return int'(c) - int'(CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UZ)
			return int'(c) - int'(CH_UA) + 10;
		return 99;
	endfunction

	function automatic logic [7:0] digit_char(input int v);
		if (v < 10)
			return 8'(int'(CH_0) + v);
		return 8'(($urandom_range(1) ? int'(CH_LA) : int'(CH_UA)) + v - 10);
	endfunction

	function automatic logic [7:0] random_space();
		return $urandom_range(1) ? CH_SPACE : 8'(int'(CH_TAB) + $urandom_range(4));
	endfunction

	function automatic void clear_parse_model();
		m_phase = PH_WS;
		m_acc   = '0;
		m_radix = '0;
		m_pos   = '0;
		m_stop  = '0;
		m_any   = 1'b0;
		m_ovf   = 1'b0;
	endfunction

	function automatic void accept_digit(input logic [7:0] c, input logic [STOP_W-1:0] pos);
		int d;
		logic [63:0] prod;
		d = char_value(c);
		if (m_radix < RADIX_MIN || m_radix > RADIX_MAX || d >= int'(m_radix)) begin
			m_phase = PH_DONE;
			return;
		end
		m_any = 1'b1;
		prod = 64'(m_acc) * 64'(m_radix) + 64'(d);
		if (prod > 64'(VALUE_MAX)) begin
			m_ovf   = 1'b1;
			m_acc   = VALUE_MAX;
			m_stop  = pos;
			m_phase = PH_DONE;
		end else begin
			m_acc   = prod[VALUE_W-1:0];
			m_stop  = pos_next(pos);
			m_phase = PH_DIGITS;
		end
	endfunction

	// first significant byte: radix is set here; an x after a leading zero may still switch it to hex
	function automatic void begin_number(input logic [7:0] c, input logic [STOP_W-1:0] pos);
		if ((m_base == RADIX_INFER || m_base == RADIX_HEX) && c == CH_0) begin
			m_any   = 1'b1;
			m_acc   = '0;
			m_stop  = pos_next(pos);
			m_radix = (m_base == RADIX_INFER) ? RADIX_OCT : RADIX_HEX;
			m_phase = PH_ZERO;
		end else begin
			m_radix = (m_base == RADIX_INFER) ? RADIX_DEC : m_base;
			accept_digit(c, pos);
		end
	endfunction

	function automatic void predict_parse(input logic [7:0] c, input logic lst);
		logic [STOP_W-1:0] pos;
		result_t r;
		pos = m_pos;
		if (c != CH_NUL) begin
			case (m_phase)
				PH_WS: begin
					if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
						if (c == CH_PLUS)
							m_phase = PH_SIGN;
						else
							begin_number(c, pos);
					end
				end
				PH_SIGN: begin
					begin_number(c, pos);
				end
				PH_ZERO: begin
					if (c == CH_LX || c == CH_UX) begin
						m_radix = RADIX_HEX;
						m_phase = PH_DIGITS;
					end else begin
						accept_digit(c, pos);
					end
				end
				PH_DIGITS: begin
					accept_digit(c, pos);
				end
				default: begin
				end
			endcase
			m_pos = pos_next(pos);
		end
		if (c == CH_NUL || lst) begin
			r.value      = m_any ? m_acc : '0;
			r.stop       = m_any ? m_stop : '0;
			r.converted  = m_any;
			r.overflowed = m_ovf;
			expected_numbers.push_back(r);
			n_strings++;
			if (m_ovf)
				n_overflow++;
			clear_parse_model();
		end
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic lst);
		int gap;
		gap = tx_idling ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		char_code <= c;
		last_byte <= lst;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
			n_stalled++;
		end
		predict_parse(c, lst);
		tx_total++;
	endtask

	// text, ended by a zero byte or by last_byte on its final character
	task automatic send_text(input string t, input bit nul_end);
		for (int i = 0; i < t.len(); i++)
			send_byte(t[i], !nul_end && i == t.len() - 1);
		if (nul_end)
			send_byte(CH_NUL, 1'b0);
	endtask

	// only once the parser has gone quiet
	task automatic set_radix(input logic [BASE_W-1:0] b);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_numbers.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAUSE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= b;
		@(negedge clk);
		cfg_we <= 1'b0;
		m_base = b;
	endtask

	task automatic send_random_string();
		logic [8:0] s[$];
		int r;
		int radix;
		int n;
		int style;
		int v;
		r = $urandom_range(99);
		style = 3;
		if (r < 15) begin
			// pure noise, may hold zero bytes of its own
			n = $urandom_range(1, 6);
			repeat (n) s.push_back({1'b0, 8'($urandom_range(255))});
		end else begin
			n = $urandom_range(0, 2);
			repeat (n) s.push_back({1'b0, random_space()});
			if ($urandom_range(3) == 0)
				s.push_back({1'b0, CH_PLUS});
			radix = int'(m_base);
			if (m_base == RADIX_INFER) begin
				style = $urandom_range(2);
				if (style == 0) begin
					s.push_back({1'b0, CH_0});
					s.push_back({1'b0, $urandom_range(1) ? CH_LX : CH_UX});
					radix = 16;
				end else if (style == 1) begin
					s.push_back({1'b0, CH_0});
					radix = 8;
				end else begin
					radix = 10;
				end
			end else if (m_base == RADIX_HEX && $urandom_range(1)) begin
				s.push_back({1'b0, CH_0});
				s.push_back({1'b0, $urandom_range(1) ? CH_LX : CH_UX});
			end
			if (radix < 2 || radix > 36)
				radix = 36;
			v = $urandom_range(99);
			if (v < 70)
				n = $urandom_range(1, 6);
			else if (v < 90)
				n = $urandom_range(7, 12);
			else
				n = $urandom_range(13, 20);
			if (radix <= 4)
				n = n * 3;
			for (int i = 0; i < n; i++) begin
				v = $urandom_range(radix - 1);
				if (style == 2 && i == 0 && v == 0)
					v = 1;
				s.push_back({1'b0, digit_char(v)});
			end
			// broken sequence: one byte replaced by something arbitrary
			if (r < 25)
				s[$urandom_range(s.size() - 1)] = {1'b0, 8'($urandom_range(1, 255))};
		end
		case ($urandom_range(3))
			0: begin
				s.push_back({1'b0, CH_NUL});
			end
			1: begin
				s[s.size() - 1][8] = 1'b1;
			end
			2: begin
				s.push_back({1'b0, 8'($urandom_range(1, 255))});
				s.push_back({1'b0, CH_NUL});
			end
			default: begin
				s.push_back({1'b1, 8'($urandom_range(255))});
			end
		endcase
		foreach (s[i])
			send_byte(s[i][7:0], s[i][8]);
	endtask

	task automatic test_prefix_inference();
		// radix register still at its reset value
		send_text(" 0x1f", 1'b0);
		send_text("017", 1'b1);
		send_text("0xg", 1'b0);
		send_text("+ 5", 1'b1);
		send_text("", 1'b1);
		send_byte("9", 1'b0);
		send_byte(8'hff, 1'b1);
	endtask

	task automatic test_fixed_radix();
		set_radix(RADIX_HEX);
		send_text("0X1a", 1'b1);
		send_text("010", 1'b1);
		send_text("ffffffff", 1'b0);
		set_radix(RADIX_MIN);
		send_text("102", 1'b0);
	endtask

	task automatic test_invalid_radix();
		set_radix(6'd1);
		send_text("1", 1'b1);
		set_radix(6'd63);
		send_text("a", 1'b1);
		set_radix(6'd37);
		send_text("z", 1'b1);
	endtask

	task automatic test_overflow_limits();
		set_radix(RADIX_MAX);
		send_text("Zz", 1'b0);
		send_text("ZZZZZZZ", 1'b1);
	endtask

	task automatic test_long_prefix();
		set_radix(RADIX_DEC);
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		// long whitespace run ahead of the digits
		repeat (40) send_byte(random_space(), 1'b0);
		send_text("12345", 1'b0);
		tx_idling = 1'b1;
		rx_idling = 1'b1;
	endtask

	task automatic test_backpressure();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		hold_left = 300;
		repeat (40) begin
			send_byte(digit_char($urandom_range(9)), 1'b0);
			send_byte(CH_NUL, 1'b0);
		end
		tx_idling = 1'b1;
		rx_idling = 1'b1;
	endtask

	task automatic test_random_strings();
		logic [BASE_W-1:0] plan [8];
		int start;
		plan[0] = RADIX_INFER;
		plan[1] = RADIX_HEX;
		plan[2] = RADIX_DEC;
		plan[3] = RADIX_OCT;
		plan[4] = RADIX_MIN;
		plan[5] = RADIX_MAX;
		plan[6] = 6'($urandom_range(63));
		plan[7] = RADIX_INFER;
		for (int p = 0; p < 8; p++) begin
			set_radix(plan[p]);
			tx_idling = (p % 4 != 3);
			rx_idling = (p % 3 != 2);
			start = tx_total;
			while (tx_total - start < 90)
				send_random_string();
		end
		tx_idling = 1'b1;
		rx_idling = 1'b1;
	endtask

	task automatic flag_mismatch(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		errors++;
		$display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_numbers.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result, expected none, got value %h stop %h",
					$time, parsed_value, stop_offset);
			end else begin
				want = expected_numbers.pop_front();
				checked++;
				if (parsed_value !== want.value)
					flag_mismatch("parsed_value", want.value, parsed_value);
				if (stop_offset !== want.stop)
					flag_mismatch("stop_offset", 32'(want.stop), 32'(stop_offset));
				if (converted !== want.converted)
					flag_mismatch("converted", 32'(want.converted), 32'(converted));
				if (overflowed !== want.overflowed)
					flag_mismatch("overflowed", 32'(want.overflowed), 32'(overflowed));
			end
		end
	end

	// result side: random stalls, plus a long hold when asked for
	initial begin : result_receiver
		int run;
		run = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (run > 0) begin
				out_stall <= 1'b1;
				run--;
			end else if (rx_idling) begin
				run = pick_gap();
				out_stall <= (run > 0);
				if (run > 0)
					run--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycles, expected_numbers.size());
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		char_code = '0;
		last_byte = 1'b0;
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		hold_left = 0;
		errors    = 0;
		checked   = 0;
		n_strings = 0;
		n_overflow = 0;
		n_stalled = 0;
		tx_total  = 0;
		m_base    = RADIX_INFER;
		clear_parse_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_prefix_inference();
		test_fixed_radix();
		test_invalid_radix();
		test_overflow_limits();
		set_radix(RADIX_DEC);
		test_backpressure();
		test_long_prefix();
		test_random_strings();

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_numbers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d strings (%0d overflowing) in %0d bytes, radix settings 0 to 63",
			n_strings, n_overflow, tx_total);
		$display("%0d results compared, input held off for %0d cycles, %0d errors",
			checked, n_stalled, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
